// File: hdl/stq_pkg.sv
package stq_pkg;

    // Default build values
    localparam int NUM_VOICES_DEF  = 4;
    localparam int MAX_TONES_DEF   = 256;
    localparam int SAMPLE_RATE_DEF = 32768;

    localparam int         PHASE_STEP = 4;
    localparam logic [18:0] FRAME_MAX = 19'h7FFFF;

    // Command codes on the cmd field
    typedef enum logic [2:0] {
        CMD_FRAME = 3'd0,
        CMD_TICK  = 3'd1,
        CMD_TONE  = 3'd2,
        CMD_VOICE = 3'd3,
        CMD_START = 3'd4
    } cmd_code_t;

    // Register indexes on the config port
    localparam logic REG_NUM_VOICES = 1'b0;
    localparam logic REG_DC_OFFSET  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic exec;
        logic frame_init;
        logic fetch;
        logic check;
        logic div_period;
        logic div_mod;
        logic accum;
        logic next_voice;
        logic out_load;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic started;
        logic voice_end;
        logic voice_done;
        logic expired;
        logic last_note;
        logic freq_zero;
        logic div_done;
        logic res_full;
    } dp_status_t;

endpackage

// File: hdl/square_wave_tone_sequencer.sv
// Channel   Direction  Handshake            Payload
// command   in         cmd_valid/cmd_stall  cmd voice tone_slot tone_frequency
//                                           tone_length note_count amplitude
// result    out        res_valid/res_stall  frame_value idle
// config    in         APB write/read       voice_limit (0x0) dc_offset (0x4)
//
// Non-frame commands execute when accepted. A frame walks the voices in turn: a
// finished voice is skipped, a voice whose last note ends or that is silent moves
// on, and a sounding voice runs the shared 32-step divider twice (period, then phase modulo).
// Reset clears all control and per-voice state; the tone store is not cleared.
// A frame command is stalled while the previous result waits to be taken.
module square_wave_tone_sequencer #(
    parameter int NUM_VOICES     = stq_pkg::NUM_VOICES_DEF,
    parameter int MAX_TONES      = stq_pkg::MAX_TONES_DEF,
    parameter int SAMPLE_RATE_HZ = stq_pkg::SAMPLE_RATE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [2:0]  cmd,
    input  logic [1:0]  voice,
    input  logic [7:0]  tone_slot,
    input  logic [15:0] tone_frequency,
    input  logic [31:0] tone_length,
    input  logic [8:0]  note_count,
    input  logic [15:0] amplitude,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [18:0] frame_value,
    output logic        idle,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import stq_pkg::*;

    logic [2:0]  voice_limit_reg;
    logic [15:0] dc_offset_reg;
    logic        wr_en;
    ctrl_cmd_t   ctl;
    dp_status_t  st;

    // Config registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            voice_limit_reg <= '0;
            dc_offset_reg   <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                REG_NUM_VOICES: voice_limit_reg <= pwdata[2:0];
                REG_DC_OFFSET:  dc_offset_reg   <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_NUM_VOICES: prdata = 32'(voice_limit_reg);
            REG_DC_OFFSET:  prdata = 32'(dc_offset_reg);
            default:        prdata = '0;
        endcase
    end

    stq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_is_frame(cmd == CMD_FRAME),
        .cmd_stall   (cmd_stall),
        .st          (st),
        .ctl         (ctl)
    );

    stq_datapath #(
        .NUM_VOICES    (NUM_VOICES),
        .MAX_TONES     (MAX_TONES),
        .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .st            (st),
        .cmd           (cmd),
        .voice         (voice),
        .tone_slot     (tone_slot),
        .tone_frequency(tone_frequency),
        .tone_length   (tone_length),
        .note_count    (note_count),
        .amplitude     (amplitude),
        .voice_limit   (voice_limit_reg),
        .dc_offset     (dc_offset_reg),
        .frame_value   (frame_value),
        .idle          (idle),
        .res_valid     (res_valid),
        .res_stall     (res_stall)
    );

endmodule

// File: hdl/stq_div.sv
module stq_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CNW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   quo_reg, quo_next;
    logic [W-1:0]   den_reg;
    logic [CNW-1:0] cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [W:0]     trial;
    logic           ge;

    // One restoring step per cycle
    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        ge       = (trial >= {1'b0, den_reg});
        rem_next = ge ? W'(trial - {1'b0, den_reg}) : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// File: hdl/stq_datapath.sv
module stq_datapath #(
    parameter int NUM_VOICES     = stq_pkg::NUM_VOICES_DEF,
    parameter int MAX_TONES      = stq_pkg::MAX_TONES_DEF,
    parameter int SAMPLE_RATE_HZ = stq_pkg::SAMPLE_RATE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  stq_pkg::ctrl_cmd_t  ctl,
    output stq_pkg::dp_status_t st,
    input  logic [2:0]          cmd,
    input  logic [1:0]          voice,
    input  logic [7:0]          tone_slot,
    input  logic [15:0]         tone_frequency,
    input  logic [31:0]         tone_length,
    input  logic [8:0]          note_count,
    input  logic [15:0]         amplitude,
    input  logic [2:0]          voice_limit,
    input  logic [15:0]         dc_offset,
    output logic [18:0]         frame_value,
    output logic                idle,
    output logic                res_valid,
    input  logic                res_stall
);
    import stq_pkg::*;

    localparam int DEPTH = NUM_VOICES * MAX_TONES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
    localparam int CW    = $clog2(MAX_TONES + 1);
    localparam int VW    = $clog2(NUM_VOICES + 1);
    localparam int VIW   = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
    localparam int PW    = $clog2(SAMPLE_RATE_HZ + 1);

    // Sequencer state
    logic [31:0]   tick_reg;
    logic          started_reg;
    logic [TW-1:0] cur_reg   [NUM_VOICES];
    logic [31:0]   start_reg [NUM_VOICES];
    logic          fin_reg   [NUM_VOICES];
    logic [CW-1:0] count_reg [NUM_VOICES];
    logic [15:0]   amp_reg   [NUM_VOICES];

    // Tone store
    logic [15:0] freq_mem [DEPTH];
    logic [31:0] len_mem  [DEPTH];
    logic [15:0] freq_rd_reg;
    logic [31:0] len_rd_reg;

    // Frame walk
    logic [VW-1:0] vi_reg;
    logic [18:0]   sum_reg;
    logic          playing_reg;
    logic [PW-1:0] period_reg;

    // Result register
    logic          res_valid_reg;
    logic [18:0]   frame_value_reg;
    logic          idle_reg;

    logic [VIW-1:0] vx;
    logic [VIW-1:0] wv;
    logic [VW-1:0]  n_eff;
    logic           tone_ok;
    logic           voice_ok;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic           rd_en;
    logic [TW:0]    next_note;
    logic           expired;
    logic           last_note;
    logic [31:0]    phase_t;
    logic           div_start;
    logic [31:0]    div_a;
    logic [31:0]    div_b;
    logic [31:0]    div_q;
    logic [31:0]    div_r;
    logic           div_done;
    logic [PW-1:0]  period_c;
    logic [15:0]    level;
    logic [19:0]    sum_wide;
    logic [CW-1:0]  count_sat;

    assign vx = vi_reg[VIW-1:0];
    assign wv = VIW'(voice);

    always_comb
    begin
        n_eff     = (32'(voice_limit) > NUM_VOICES) ? VW'(NUM_VOICES) : VW'(voice_limit);
        voice_ok  = (32'(voice) < NUM_VOICES);
        tone_ok   = voice_ok && (32'(tone_slot) < MAX_TONES);
        wr_addr   = AW'(32'(voice) * MAX_TONES + 32'(tone_slot));
        count_sat = (32'(note_count) > MAX_TONES) ? CW'(MAX_TONES) : CW'(note_count);
        next_note = {1'b0, cur_reg[vx]} + 1'b1;
        expired   = (tick_reg >= (start_reg[vx] + len_rd_reg));
        last_note = (32'(next_note) >= 32'(count_reg[vx]));
        phase_t   = tick_reg + 32'(vi_reg) * PHASE_STEP;
        // fetch reads the current note; an expiry that moves on reads the next
        if (ctl.check)
            rd_addr = AW'(32'(vi_reg) * MAX_TONES + 32'(next_note));
        else
            rd_addr = AW'(32'(vi_reg) * MAX_TONES + 32'(cur_reg[vx]));
        rd_en     = ctl.fetch || (ctl.check && expired && !last_note);
    end

    // Tone store write and registered read
    always_ff @(posedge clk)
    begin
        if (ctl.exec && cmd == CMD_TONE && tone_ok)
        begin
            freq_mem[wr_addr] <= tone_frequency;
            len_mem[wr_addr]  <= tone_length;
        end
        if (rd_en)
        begin
            freq_rd_reg <= freq_mem[rd_addr];
            len_rd_reg  <= len_mem[rd_addr];
        end
    end

    // Shared divider: period, then phase modulo period
    assign div_start = ctl.div_period || ctl.div_mod;
    assign period_c  = (div_q[PW-1:0] == '0) ? PW'(1) : div_q[PW-1:0];
    assign div_a     = ctl.div_mod ? phase_t : 32'(SAMPLE_RATE_HZ);
    assign div_b     = ctl.div_mod ? 32'(period_c) : 32'(freq_rd_reg);

    stq_div #(
        .W(32)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .quotient (div_q),
        .remainder(div_r),
        .done     (div_done)
    );

    // Level and saturating sum
    always_comb
    begin
        level    = (div_r < 32'(period_reg >> 1)) ? 16'd0 : amp_reg[vx];
        sum_wide = {1'b0, sum_reg} + 20'(dc_offset) + 20'(level);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_mod)
            period_reg <= period_c;
    end

    // Control and per-voice state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg      <= '0;
            started_reg   <= 1'b0;
            vi_reg        <= '0;
            sum_reg       <= '0;
            playing_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_VOICES; i++)
            begin
                cur_reg[i]   <= '0;
                start_reg[i] <= '0;
                fin_reg[i]   <= 1'b0;
                count_reg[i] <= '0;
                amp_reg[i]   <= '0;
            end
        end
        else
        begin
            if (ctl.exec)
            begin
                case (cmd)
                    CMD_TICK:
                    begin
                        tick_reg <= tick_reg + 32'd1;
                    end
                    CMD_VOICE:
                    begin
                        if (voice_ok)
                        begin
                            count_reg[wv] <= count_sat;
                            amp_reg[wv]   <= amplitude;
                        end
                    end
                    CMD_START:
                    begin
                        started_reg <= 1'b1;
                        for (int i = 0; i < NUM_VOICES; i++)
                        begin
                            if (i < 32'(n_eff))
                            begin
                                cur_reg[i]   <= '0;
                                start_reg[i] <= tick_reg;
                                fin_reg[i]   <= 1'b0;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (ctl.frame_init)
            begin
                vi_reg      <= '0;
                sum_reg     <= '0;
                playing_reg <= 1'b0;
            end
            if (ctl.fetch)
                playing_reg <= 1'b1;
            if (ctl.check && expired)
            begin
                start_reg[vx] <= start_reg[vx] + len_rd_reg;
                if (last_note)
                begin
                    cur_reg[vx] <= '0;
                    fin_reg[vx] <= 1'b1;
                end
                else
                    cur_reg[vx] <= next_note[TW-1:0];
            end
            if (ctl.accum)
                sum_reg <= sum_wide[19] ? FRAME_MAX : sum_wide[18:0];
            if (ctl.next_voice)
                vi_reg <= vi_reg + 1'b1;
            // Result beat
            if (ctl.out_load)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            frame_value_reg <= sum_reg;
            idle_reg        <= !playing_reg;
        end
    end

    assign frame_value = frame_value_reg;
    assign idle        = idle_reg;
    assign res_valid   = res_valid_reg;

    always_comb
    begin
        st.started    = started_reg;
        st.voice_end  = (vi_reg >= n_eff);
        st.voice_done = fin_reg[vx];
        st.expired    = expired;
        st.last_note  = last_note;
        st.freq_zero  = (freq_rd_reg == 16'd0);
        st.div_done   = div_done;
        st.res_full   = res_valid_reg;
    end

endmodule

// File: hdl/stq_ctrl.sv
module stq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_is_frame,
    output logic                cmd_stall,
    input  stq_pkg::dp_status_t st,
    output stq_pkg::ctrl_cmd_t  ctl
);
    import stq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_VOICE = 7'b0000010,
        S_CHECK = 7'b0000100,
        S_FREQ  = 7'b0001000,
        S_DIVP  = 7'b0010000,
        S_DIVM  = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // A frame needs the result register free
    assign cmd_stall = (state_reg != S_IDLE) || (cmd_is_frame && st.res_full);
    assign accept    = cmd_valid && !cmd_stall;

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_is_frame)
                    begin
                        ctl.frame_init = 1'b1;
                        state_next     = S_VOICE;
                    end
                    else
                        ctl.exec = 1'b1;
                end
            end
            S_VOICE:
            begin
                if (!st.started || st.voice_end)
                    state_next = S_OUT;
                else if (st.voice_done)
                    ctl.next_voice = 1'b1;
                else
                begin
                    ctl.fetch  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                ctl.check = 1'b1;
                if (st.expired && st.last_note)
                begin
                    ctl.next_voice = 1'b1;
                    state_next     = S_VOICE;
                end
                else
                    state_next = S_FREQ;
            end
            S_FREQ:
            begin
                if (st.freq_zero)
                begin
                    ctl.next_voice = 1'b1;
                    state_next     = S_VOICE;
                end
                else
                begin
                    ctl.div_period = 1'b1;
                    state_next     = S_DIVP;
                end
            end
            S_DIVP:
            begin
                if (st.div_done)
                begin
                    ctl.div_mod = 1'b1;
                    state_next  = S_DIVM;
                end
            end
            S_DIVM:
            begin
                if (st.div_done)
                begin
                    ctl.accum      = 1'b1;
                    ctl.next_voice = 1'b1;
                    state_next     = S_VOICE;
                end
            end
            S_OUT:
            begin
                if (!st.res_full)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> state_reg == S_IDLE)
        else $error("beat taken while busy");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> !st.res_full)
        else $error("result overwritten");

    a_div_chain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVP && st.div_done) |=> state_reg == S_DIVM)
        else $error("modulo step skipped");

    a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |=> st.res_full)
        else $error("result not posted");

endmodule
